FILE: rtl/core/sorted_string_table_defines.svh
// assertion macros for the sorted string table rtl
// no dependencies; included by files that carry assertions
`ifndef SORTED_STRING_TABLE_DEFINES_SVH
`define SORTED_STRING_TABLE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, disabled during reset
`define SST_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, disabled during reset
`define SST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SST_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define SST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/core/sst_pkg.sv
// shared types and codes for the sorted string table
// no dependencies
package sst_pkg;

  localparam int KEY_W = 152;

  // operation codes
  localparam logic [2:0] OP_INSERT     = 3'd0;
  localparam logic [2:0] OP_REM_FIRST  = 3'd1;
  localparam logic [2:0] OP_REM_LAST   = 3'd2;
  localparam logic [2:0] OP_SEARCH     = 3'd3;
  localparam logic [2:0] OP_READ_AT    = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_EMPTY      = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
  localparam logic [2:0] ST_FULL       = 3'd3;
  localparam logic [2:0] ST_RANGE      = 3'd4;

  typedef struct packed {
    logic [63:0] high;
    logic [63:0] middle;
    logic [23:0] low;
  } sst_key_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] key_high;
    logic [63:0] key_middle;
    logic [23:0] key_low;
    logic [3:0]  read_index;
  } sst_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  entry_total;
    logic [63:0] read_high;
    logic [63:0] read_middle;
    logic [23:0] read_low;
  } sst_out_t;

  // result of the shared key comparator
  typedef struct packed {
    logic gt;
    logic eq;
  } sst_cmp_t;

endpackage

FILE: rtl/core/sorted_string_table.sv
// Sorted string table: keeps up to ENTRY_DEPTH keys in ascending order.
// Input channel (in_valid, in_stall, in_data) takes one request: insert,
// remove first, remove last, search or read at index. The block takes one
// request at a time; in_stall stays high from acceptance until its result is
// loaded into the output register, which may still be waiting to be taken.
// Output channel (out_valid, out_stall, out_data) gives one result per
// request: status, entry count after the operation and the key read.
// Steps after acceptance: insert walks down from the top key, moving
// larger keys up one place, and writes the new key below them (S_PUT when
// it is the smallest); remove first moves every key down one place; search
// scans upward for an exact match; read at index waits for the store's
// registered read; remove last, full, empty, range and unused codes go
// straight to the response step. The scans are paced by the single read
// and write port of the key store: each cycle one entry is read, and
// compared by the shared comparator or moved.
// While out_stall holds an untaken result in the output register, a new
// result waits in the sequencer. Reset empties the table, clears out_valid
// and in_stall; the key store itself is not cleared.
// depends on sst_pkg, sst_cmp, sst_mem and sorted_string_table_defines.svh
`include "sorted_string_table_defines.svh"
module sorted_string_table #(
  parameter int ENTRY_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sst_pkg::sst_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sst_pkg::sst_out_t out_data
);

  localparam int AW = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
  localparam int CW = $clog2(ENTRY_DEPTH + 1);
  localparam int RW = (CW > 4) ? CW : 4;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_INS  = 7'b0000010,
    S_PUT  = 7'b0000100,
    S_RMF  = 7'b0001000,
    S_SRCH = 7'b0010000,
    S_RDW  = 7'b0100000,
    S_RESP = 7'b1000000
  } sst_state_t;

  sst_state_t        state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  sst_pkg::sst_key_t key_r, key_nxt;
  logic [2:0]        res_status_r, res_status_nxt;
  sst_pkg::sst_key_t res_read_r, res_read_nxt;
  logic              out_valid_r, out_valid_nxt;
  sst_pkg::sst_out_t out_data_r, out_data_nxt;

  logic              in_acc;
  logic              out_free;
  sst_pkg::sst_key_t in_key;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  sst_pkg::sst_key_t mem_wdata;
  logic [AW-1:0]     mem_raddr;
  sst_pkg::sst_key_t mem_rdata;
  sst_pkg::sst_cmp_t cmp_res;
  logic              idx_last;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_key.high   = in_data.key_high;
  assign in_key.middle = in_data.key_middle;
  assign in_key.low    = in_data.key_low;

  // scan index sits on the last stored entry
  assign idx_last = (CW'(idx_r) == count_r - CW'(1));

  sst_mem #(
    .DEPTH (ENTRY_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sst_cmp u_cmp (
    .entry (mem_rdata),
    .key   (key_r),
    .res   (cmp_res)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    key_nxt        = key_r;
    res_status_nxt = res_status_r;
    res_read_nxt   = res_read_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r + AW'(1);
    mem_wdata      = mem_rdata;
    mem_raddr      = '0;

    // a taken result frees the output register
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          key_nxt        = in_key;
          res_status_nxt = sst_pkg::ST_OK;
          res_read_nxt   = '0;
          state_nxt      = S_RESP;
          case (in_data.op)
            sst_pkg::OP_INSERT: begin
              mem_raddr = AW'(count_r - CW'(1));
              if (count_r == CW'(ENTRY_DEPTH)) begin
                res_status_nxt = sst_pkg::ST_FULL;
              end else if (count_r == '0) begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = in_key;
                count_nxt = count_r + CW'(1);
              end else begin
                idx_nxt   = AW'(count_r - CW'(1));
                state_nxt = S_INS;
              end
            end
            sst_pkg::OP_REM_FIRST: begin
              mem_raddr = AW'(1);
              if (count_r == '0) begin
                res_status_nxt = sst_pkg::ST_EMPTY;
              end else if (count_r == CW'(1)) begin
                count_nxt = '0;
              end else begin
                idx_nxt   = AW'(1);
                state_nxt = S_RMF;
              end
            end
            sst_pkg::OP_REM_LAST: begin
              if (count_r == '0) begin
                res_status_nxt = sst_pkg::ST_EMPTY;
              end else begin
                count_nxt = count_r - CW'(1);
              end
            end
            sst_pkg::OP_SEARCH: begin
              mem_raddr = '0;
              if (count_r == '0) begin
                res_status_nxt = sst_pkg::ST_NOT_FOUND;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_SRCH;
              end
            end
            sst_pkg::OP_READ_AT: begin
              mem_raddr = AW'(in_data.read_index);
              if (RW'(in_data.read_index) >= RW'(count_r)) begin
                res_status_nxt = sst_pkg::ST_RANGE;
              end else begin
                state_nxt = S_RDW;
              end
            end
            default: begin
              res_status_nxt = sst_pkg::ST_OK;
            end
          endcase
        end
      end

      // walk down from the top, moving larger entries up one place
      S_INS: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r + AW'(1);
        mem_raddr = idx_r - AW'(1);
        if (cmp_res.gt) begin
          mem_wdata = mem_rdata;
          if (idx_r == '0) begin
            state_nxt = S_PUT;
          end else begin
            idx_nxt = idx_r - AW'(1);
          end
        end else begin
          mem_wdata = key_r;
          count_nxt = count_r + CW'(1);
          state_nxt = S_RESP;
        end
      end

      // new key is the smallest
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = key_r;
        count_nxt = count_r + CW'(1);
        state_nxt = S_RESP;
      end

      // move every entry down one place
      S_RMF: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r - AW'(1);
        mem_wdata = mem_rdata;
        mem_raddr = idx_r + AW'(1);
        if (idx_last) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_RESP;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end

      // linear search for an exact match
      S_SRCH: begin
        mem_raddr = idx_r + AW'(1);
        if (cmp_res.eq) begin
          res_status_nxt = sst_pkg::ST_OK;
          state_nxt      = S_RESP;
        end else if (idx_last) begin
          res_status_nxt = sst_pkg::ST_NOT_FOUND;
          state_nxt      = S_RESP;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end

      // read data arrives from the store
      S_RDW: begin
        res_read_nxt = mem_rdata;
        state_nxt    = S_RESP;
      end

      // hand the result to the output register
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = res_status_r;
          out_data_nxt.entry_total = 5'(count_r);
          out_data_nxt.read_high   = res_read_r.high;
          out_data_nxt.read_middle = res_read_r.middle;
          out_data_nxt.read_low    = res_read_r.low;
          state_nxt                = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    key_r        <= key_nxt;
    res_status_r <= res_status_nxt;
    res_read_r   <= res_read_nxt;
    out_data_r   <= out_data_nxt;
  end

  `SST_ASSERT_NEXT(a_full_insert_keeps, clk, rst_n, in_acc && in_data.op == sst_pkg::OP_INSERT && count_r == CW'(ENTRY_DEPTH), count_r == $past(count_r), "insert into a full table changed the count")
  `SST_ASSERT_NEXT(a_rem_last_dec, clk, rst_n, in_acc && in_data.op == sst_pkg::OP_REM_LAST && count_r != '0, count_r == $past(count_r) - CW'(1), "remove last did not drop one entry")
  `SST_ASSERT_NOW(a_scan_in_range, clk, rst_n, state_r == S_INS || state_r == S_RMF || state_r == S_SRCH, CW'(idx_r) < count_r, "scan index beyond stored entries")
  `SST_ASSERT_NOW(a_out_from_resp, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_RESP, "result loaded outside the response step")

endmodule

FILE: rtl/core/sst_cmp.sv
// shared key comparator: orders a stored entry against the request key
// depends on sst_pkg
module sst_cmp (
  input  sst_pkg::sst_key_t entry,
  input  sst_pkg::sst_key_t key,
  output sst_pkg::sst_cmp_t res
);

  logic [sst_pkg::KEY_W-1:0] entry_v;
  logic [sst_pkg::KEY_W-1:0] key_v;

  // keys order as one unsigned number, high word first
  assign entry_v = entry;
  assign key_v   = key;
  assign res.gt  = (entry_v > key_v);
  assign res.eq  = (entry_v == key_v);

endmodule

FILE: rtl/core/sst_mem.sv
// key store: one write port, one registered read port
// depends on sst_pkg
module sst_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  sst_pkg::sst_key_t wdata,
  input  logic [AW-1:0]     raddr,
  output sst_pkg::sst_key_t rdata
);

  sst_pkg::sst_key_t mem_r [DEPTH];
  sst_pkg::sst_key_t rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: tb/tb_sorted_string_table.sv
// self-checking testbench for sorted_string_table: directed and random requests
// against a shadow copy of the sorted key table, with random idling on both sides
// depends on sst_pkg and the sorted_string_table rtl
module tb_sorted_string_table;

  localparam int SLOTS = 16;
  localparam int POOL_SIZE = 6;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 40;

  // opcodes the block treats as no-ops
  localparam logic [2:0] OP_UNUSED_A = 3'd5;
  localparam logic [2:0] OP_UNUSED_B = 3'd6;
  localparam logic [2:0] OP_UNUSED_C = 3'd7;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  sst_pkg::sst_in_t  in_data;
  logic              out_valid;
  logic              out_stall;
  sst_pkg::sst_out_t out_data;

  // shadow copy of the table contents
  logic [sst_pkg::KEY_W-1:0] shadow_keys [SLOTS];
  int                        shadow_count = 0;
  logic [sst_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

  sst_pkg::sst_out_t awaited_results [$];
  int                fail_count = 0;
  int                cycle_count = 0;
  bit                sender_eager = 1'b0;
  bit                receiver_eager = 1'b0;

  sorted_string_table #(
    .ENTRY_DEPTH(SLOTS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // apply one request to the shadow table and return the result it should give
  function automatic sst_pkg::sst_out_t predict_table_op(input sst_pkg::sst_in_t req);
    sst_pkg::sst_out_t         res;
    logic [sst_pkg::KEY_W-1:0] key;
    int                        pos;
    int                        i;
    res = '0;
    key = {req.key_high, req.key_middle, req.key_low};
    case (req.op)
      sst_pkg::OP_INSERT: begin
        if (shadow_count >= SLOTS) begin
          res.status = sst_pkg::ST_FULL;
        end else begin
          // new key lands after any equal keys
          pos = 0;
          while (pos < shadow_count && shadow_keys[pos] <= key) pos++;
          for (i = shadow_count; i > pos; i--) shadow_keys[i] = shadow_keys[i - 1];
          shadow_keys[pos] = key;
          shadow_count++;
        end
      end
      sst_pkg::OP_REM_FIRST: begin
        if (shadow_count == 0) begin
          res.status = sst_pkg::ST_EMPTY;
        end else begin
          for (i = 0; i + 1 < shadow_count; i++) shadow_keys[i] = shadow_keys[i + 1];
          shadow_count--;
        end
      end
      sst_pkg::OP_REM_LAST: begin
        if (shadow_count == 0) res.status = sst_pkg::ST_EMPTY;
        else shadow_count--;
      end
      sst_pkg::OP_SEARCH: begin
        res.status = sst_pkg::ST_NOT_FOUND;
        for (i = 0; i < shadow_count; i++) begin
          if (shadow_keys[i] == key) res.status = sst_pkg::ST_OK;
        end
      end
      sst_pkg::OP_READ_AT: begin
        if (int'(req.read_index) >= shadow_count) begin
          res.status = sst_pkg::ST_RANGE;
        end else begin
          {res.read_high, res.read_middle, res.read_low} = shadow_keys[req.read_index];
        end
      end
      default: begin
      end
    endcase
    res.entry_total = 5'(shadow_count);
    return res;
  endfunction

  // printable text key of 0 to 19 characters, zero padded
  function automatic logic [sst_pkg::KEY_W-1:0] text_key();
    logic [sst_pkg::KEY_W-1:0] k;
    int                        len;
    int                        c;
    k = '0;
    len = $urandom_range(0, 19);
    for (c = 0; c < len; c++) begin
      k[sst_pkg::KEY_W - 1 - 8 * c -: 8] = 8'($urandom_range(32, 126));
    end
    return k;
  endfunction

  // mix of raw bits, repeated keys, near misses and text
  function automatic logic [sst_pkg::KEY_W-1:0] random_key();
    logic [sst_pkg::KEY_W-1:0] k;
    case ($urandom_range(0, 9))
      0, 1, 2: k = {$urandom, $urandom, $urandom, $urandom, 24'($urandom)};
      3, 4, 5: k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      6, 7: begin
        k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        k[23:0] = 24'($urandom_range(0, 3));
      end
      default: k = text_key();
    endcase
    return k;
  endfunction

  // present one request after a random gap and record its expected result
  task automatic send_request(input logic [2:0] op, input logic [sst_pkg::KEY_W-1:0] key,
                              input logic [3:0] idx);
    int gap;
    gap = sender_eager ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= sst_pkg::sst_in_t'({op, key, idx});
    do @(posedge clk); while (in_stall !== 1'b0);
    awaited_results.push_back(predict_table_op(in_data));
    @(negedge clk);
  endtask

  // hold off new requests until every outstanding result is back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
    end
  endtask

  // result side: random stall per result, compare against oldest expectation
  initial begin : result_checker
    sst_pkg::sst_out_t want;
    int                hold;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      hold = receiver_eager ? 0 : $urandom_range(0, 18);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
      if (awaited_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none actual %h", $time, out_data);
      end else begin
        want = awaited_results.pop_front();
        check_field("status", 64'(want.status), 64'(out_data.status));
        check_field("entry_total", 64'(want.entry_total), 64'(out_data.entry_total));
        check_field("read_high", want.read_high, out_data.read_high);
        check_field("read_middle", want.read_middle, out_data.read_middle);
        check_field("read_low", 64'(want.read_low), 64'(out_data.read_low));
      end
    end
  end

  // run limit
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sorted_string_table regression: fail");
    $finish;
  end

  // every operation but insert on an empty table, plus the unused opcodes
  task automatic test_empty_table();
    send_request(sst_pkg::OP_REM_FIRST, '0, 4'd0);
    send_request(sst_pkg::OP_REM_LAST, '1, 4'd15);
    send_request(sst_pkg::OP_SEARCH, '0, 4'd0);
    send_request(sst_pkg::OP_READ_AT, '0, 4'd0);
    send_request(OP_UNUSED_A, '1, 4'd15);
    send_request(OP_UNUSED_B, '0, 4'd0);
    send_request(OP_UNUSED_C, '1, 4'd3);
  endtask

  // extreme keys, a duplicate, a low-word neighbor and bytes after a zero
  task automatic test_key_ordering();
    logic [sst_pkg::KEY_W-1:0] key_mid;
    logic [sst_pkg::KEY_W-1:0] key_gap;
    key_mid = {64'h4D49_4444_4C45_2D4B, 64'h4559_0000_0000_0000, 24'h0};
    key_gap = {64'h4142_0043_4400_0000, 64'h0, 24'h0};
    send_request(sst_pkg::OP_INSERT, key_mid, 4'd0);
    send_request(sst_pkg::OP_INSERT, '1, 4'd0);
    send_request(sst_pkg::OP_INSERT, '0, 4'd0);
    send_request(sst_pkg::OP_INSERT, key_mid, 4'd0);
    send_request(sst_pkg::OP_INSERT, {key_mid[sst_pkg::KEY_W-1:24], 24'h000001}, 4'd0);
    send_request(sst_pkg::OP_INSERT, key_gap, 4'd0);
    send_request(sst_pkg::OP_READ_AT, '0, 4'd0);
    send_request(sst_pkg::OP_READ_AT, '0, 4'd2);
    send_request(sst_pkg::OP_READ_AT, '0, 4'd5);
    send_request(sst_pkg::OP_READ_AT, '0, 4'd6);
    send_request(sst_pkg::OP_READ_AT, '0, 4'd15);
  endtask

  // exact matches only: low-word neighbor and truncated text must miss
  task automatic test_exact_search();
    send_request(sst_pkg::OP_SEARCH,
                 {64'h4D49_4444_4C45_2D4B, 64'h4559_0000_0000_0000, 24'h0}, 4'd0);
    send_request(sst_pkg::OP_SEARCH,
                 {64'h4D49_4444_4C45_2D4B, 64'h4559_0000_0000_0000, 24'h2}, 4'd0);
    send_request(sst_pkg::OP_SEARCH, {64'h4142_0000_0000_0000, 64'h0, 24'h0}, 4'd0);
    send_request(sst_pkg::OP_SEARCH, '1, 4'd0);
  endtask

  task automatic test_removal();
    send_request(sst_pkg::OP_REM_FIRST, '0, 4'd0);
    send_request(sst_pkg::OP_REM_LAST, '0, 4'd0);
  endtask

  // random requests weighted toward filling, draining or churning the table
  task automatic test_random_mix(input int count, input int insert_pct, input int remove_pct);
    int                        n;
    int                        roll;
    logic [2:0]                op;
    logic [sst_pkg::KEY_W-1:0] key;
    logic [3:0]                idx;
    for (n = 0; n < count; n++) begin
      // redraw idling mode now and then so bursts and gaps both occur
      if (n % 25 == 0) begin
        sender_eager = ($urandom_range(0, 3) == 0);
        receiver_eager = ($urandom_range(0, 3) == 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) op = OP_UNUSED_A + 3'($urandom_range(0, 2));
      else if (roll < 3 + insert_pct) op = sst_pkg::OP_INSERT;
      else if (roll < 3 + insert_pct + remove_pct)
        op = $urandom_range(0, 1) ? sst_pkg::OP_REM_FIRST : sst_pkg::OP_REM_LAST;
      else op = roll[0] ? sst_pkg::OP_SEARCH : sst_pkg::OP_READ_AT;
      // searches often hit a stored key, reads often land in range
      if (op == sst_pkg::OP_SEARCH && shadow_count > 0 && $urandom_range(0, 1))
        key = shadow_keys[$urandom_range(0, shadow_count - 1)];
      else
        key = random_key();
      if (op == sst_pkg::OP_READ_AT && shadow_count > 0 && $urandom_range(0, 1))
        idx = 4'($urandom_range(0, shadow_count - 1));
      else
        idx = 4'($urandom_range(0, 15));
      send_request(op, key, idx);
    end
    wait_for_results();
  endtask

  initial begin
    int p;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    for (p = 0; p < POOL_SIZE; p++) key_pool[p] = text_key();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_key_ordering();
    test_exact_search();
    test_removal();
    wait_for_results();

    test_random_mix(120, 70, 15);
    test_random_mix(120, 15, 60);
    test_random_mix(130, 40, 35);
    test_random_mix(130, 60, 25);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("sorted_string_table regression: pass");
    end else begin
      $display("sorted_string_table regression: fail");
    end
    $finish;
  end

endmodule

FILE: sorted_string_table.f
+incdir+rtl/core
rtl/core/sst_pkg.sv
rtl/core/sst_cmp.sv
rtl/core/sst_mem.sv
rtl/core/sorted_string_table.sv
tb/tb_sorted_string_table.sv
